@@ src/dynamic_range_kth_smallest_assert.svh @@
// Assertion macros for the dynamic range k-th smallest block.
`ifndef DYNAMIC_RANGE_KTH_SMALLEST_ASSERT_SVH
`define DYNAMIC_RANGE_KTH_SMALLEST_ASSERT_SVH
`ifndef SYNTHESIS
`define DRKS_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define DRKS_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define DRKS_ASSERT_IMPL(label, a, c)
`define DRKS_ASSERT_NEXT(label, a, c)
`endif
`endif

@@ src/drks_pkg.sv @@
// Types and constants of the dynamic range k-th smallest block.
package drks_pkg;
	localparam int DEF_MAX_POSITIONS = 64;
	localparam int FIELD_W = 7;
	localparam int RESET_SIZE = 64;
	localparam logic OP_SET = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic operation;
		logic [FIELD_W-1:0] update_position;
		logic [FIELD_W-1:0] new_value;
		logic [FIELD_W-1:0] range_left;
		logic [FIELD_W-1:0] range_right;
		logic [FIELD_W-1:0] rank;
	} drks_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] kth_value;
		logic invalid;
	} drks_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_POS,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_Q_RD,
		ST_Q_ACC,
		ST_Q_EVAL,
		ST_DONE
	} drks_state_t;
endpackage

@@ src/dynamic_range_kth_smallest.sv @@
// Dynamic range k-th smallest block: Fenwick tree of value-count trees in one memory.
//
//   channel   signals                          transfer when
//   input     in_valid, in_ready, in_data      in_valid && in_ready
//   output    out_valid, out_ready, out_data   out_valid && out_ready
//   config    cfg_wr_en, cfg_wr_data           cfg_wr_en
//
// A set item reads and then writes back, through the single count memory, the count slot
// on each tree level (log2 of the value span plus one levels) of each Fenwick node covering
// the position, once for the old value if the position held one and once for the new value.
// A query item, for each tree level, reads the count memory over both prefix chains and
// then evaluates.
// After reset and after each configuration write a clearing pass over the memories
// runs, during which no item is taken.
// The next item is taken while a result waits in the output register; a new result is
// held back until the previous one has gone.
`include "dynamic_range_kth_smallest_assert.svh"
module dynamic_range_kth_smallest #(
	parameter int MAX_POSITIONS = drks_pkg::DEF_MAX_POSITIONS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  drks_pkg::drks_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output drks_pkg::drks_out_t out_data,
	input  logic cfg_wr_en,
	input  logic [drks_pkg::FIELD_W-1:0] cfg_wr_data
);
	localparam int FW = drks_pkg::FIELD_W;
	localparam int PW = $clog2(MAX_POSITIONS + 1);
	localparam int PIW = $clog2(MAX_POSITIONS);
	localparam int VW = $clog2(MAX_POSITIONS);
	localparam int VS = 1 << VW;
	localparam int SW = VW + 1;
	localparam int AW = PIW + SW;
	localparam int DEPTH = 1 << AW;
	localparam int CW = PW;
	localparam int XW = ((PW > FW) ? PW : FW) + 1;
	localparam int RSZ = (drks_pkg::RESET_SIZE > MAX_POSITIONS) ?
		MAX_POSITIONS : drks_pkg::RESET_SIZE;
	localparam logic [XW-1:0] VS_X = XW'(VS);
	localparam logic [XW-1:0] MAX_X = XW'(MAX_POSITIONS);

	drks_pkg::drks_state_t state_q, state_d;

	logic [XW-1:0] size_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] u_q, x_q, l_q, r_q, fi_q;
	logic [FW-1:0] k_q;
	logic [SW-1:0] slot_q, span_q, lo_q;
	logic [SW-1:0] oldleaf_q;
	logic [CW-1:0] acc_q;
	logic down_q, side_q, first_q;
	drks_pkg::drks_out_t pend_q;

	logic [CW-1:0] cnt_mem [DEPTH];
	logic [CW-1:0] cnt_rdata;
	logic cnt_we;
	logic [AW-1:0] cnt_waddr, cnt_raddr;
	logic [CW-1:0] cnt_wdata;

	logic [FW-1:0] pos_mem [1 << PIW];
	logic [FW-1:0] pos_rdata;
	logic pos_we;
	logic [PIW-1:0] pos_waddr, pos_raddr;
	logic [FW-1:0] pos_wdata;

	logic [XW-1:0] in_u, in_x, in_l, in_r, in_k, cfg_x;
	logic upd_ok, q_bad, accept;
	logic [XW-1:0] fi_m1, fi_low, fi_up, fi_dn, lm1, old_x;
	logic up_more, dn_more;
	logic [SW-1:0] leaf_x, leaf_old, node_new, span_new, lo_new;
	logic [XW-1:0] k_x, acc_x;
	logic le, chain_end, upd_last;

	assign in_u = XW'(in_data.update_position);
	assign in_x = XW'(in_data.new_value);
	assign in_l = XW'(in_data.range_left);
	assign in_r = XW'(in_data.range_right);
	assign in_k = XW'(in_data.rank);
	assign cfg_x = XW'(cfg_wr_data);
	assign upd_ok = (in_u != '0) && (in_u <= size_q) && (in_x != '0) && (in_x <= size_q);
	assign q_bad = (in_l == '0) || (in_r > size_q) || (in_l > in_r) || (in_k == '0);
	assign accept = in_valid && in_ready;

	assign fi_m1 = fi_q - 1'b1;
	assign fi_low = fi_q & (~fi_q + 1'b1);
	assign fi_up = fi_q + fi_low;
	assign fi_dn = fi_q - fi_low;
	assign up_more = fi_up <= size_q;
	assign dn_more = fi_dn != '0;
	assign lm1 = l_q - 1'b1;
	assign old_x = XW'(pos_rdata);
	assign leaf_x = SW'(VS_X + x_q - 1'b1);
	assign leaf_old = SW'(VS_X + old_x - 1'b1);
	assign k_x = XW'(k_q);
	assign acc_x = XW'(acc_q);
	assign le = k_x <= acc_x;
	assign node_new = le ? slot_q : (slot_q | SW'(1));
	assign span_new = span_q >> 1;
	assign lo_new = le ? lo_q : (lo_q + span_new);
	assign chain_end = !dn_more && (side_q || (lm1 == '0));
	assign upd_last = (slot_q == SW'(1)) && !up_more && !down_q;

	assign cnt_raddr = {fi_m1[PIW-1:0], slot_q};
	assign pos_raddr = PIW'(in_u - 1'b1);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rdata <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pos_rdata <= pos_mem[pos_raddr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			drks_pkg::ST_CLEAR: begin
				if (&clr_q) state_d = drks_pkg::ST_IDLE;
			end
			drks_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_data.operation == drks_pkg::OP_QUERY) begin
						state_d = q_bad ? drks_pkg::ST_DONE : drks_pkg::ST_Q_RD;
					end else if (upd_ok) begin
						state_d = drks_pkg::ST_UPD_POS;
					end
				end
			end
			drks_pkg::ST_UPD_POS: state_d = drks_pkg::ST_UPD_RD;
			drks_pkg::ST_UPD_RD: state_d = drks_pkg::ST_UPD_WR;
			drks_pkg::ST_UPD_WR: begin
				state_d = upd_last ? drks_pkg::ST_IDLE : drks_pkg::ST_UPD_RD;
			end
			drks_pkg::ST_Q_RD: state_d = drks_pkg::ST_Q_ACC;
			drks_pkg::ST_Q_ACC: begin
				state_d = chain_end ? drks_pkg::ST_Q_EVAL : drks_pkg::ST_Q_RD;
			end
			drks_pkg::ST_Q_EVAL: begin
				if (first_q) begin
					state_d = (k_x > acc_x) ? drks_pkg::ST_DONE : drks_pkg::ST_Q_RD;
				end else begin
					state_d = (span_new == SW'(1)) ? drks_pkg::ST_DONE : drks_pkg::ST_Q_RD;
				end
			end
			drks_pkg::ST_DONE: begin
				if (!out_valid || out_ready) state_d = drks_pkg::ST_IDLE;
			end
			default: state_d = drks_pkg::ST_CLEAR;
		endcase
		if (cfg_wr_en) state_d = drks_pkg::ST_CLEAR;
	end

	always_comb begin
		in_ready = 1'b0;
		cnt_we = 1'b0;
		cnt_waddr = cnt_raddr;
		cnt_wdata = down_q ? (cnt_rdata - 1'b1) : (cnt_rdata + 1'b1);
		pos_we = 1'b0;
		pos_waddr = PIW'(u_q - 1'b1);
		pos_wdata = FW'(x_q);
		case (state_q)
			drks_pkg::ST_CLEAR: begin
				cnt_we = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				pos_we = 1'b1;
				pos_waddr = clr_q[PIW-1:0];
				pos_wdata = '0;
			end
			drks_pkg::ST_IDLE: in_ready = 1'b1;
			drks_pkg::ST_UPD_WR: begin
				cnt_we = 1'b1;
				pos_we = upd_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drks_pkg::ST_CLEAR;
			size_q <= XW'(RSZ);
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == drks_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_wr_en) begin
				clr_q <= '0;
				if (cfg_x == '0) size_q <= XW'(1);
				else if (cfg_x > MAX_X) size_q <= MAX_X;
				else size_q <= cfg_x;
			end
			if (state_q == drks_pkg::ST_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			drks_pkg::ST_IDLE: begin
				u_q <= in_u;
				x_q <= in_x;
				l_q <= in_l;
				r_q <= in_r;
				fi_q <= in_r;
				k_q <= in_data.rank;
				slot_q <= SW'(1);
				span_q <= SW'(VS);
				lo_q <= SW'(1);
				acc_q <= '0;
				side_q <= 1'b0;
				first_q <= 1'b1;
				pend_q.kth_value <= '0;
				pend_q.invalid <= 1'b1;
			end
			drks_pkg::ST_UPD_POS: begin
				fi_q <= u_q;
				if (pos_rdata != '0) begin
					down_q <= 1'b1;
					slot_q <= leaf_old;
				end else begin
					down_q <= 1'b0;
					slot_q <= leaf_x;
				end
			end
			drks_pkg::ST_UPD_WR: begin
				if (slot_q != SW'(1)) begin
					slot_q <= slot_q >> 1;
				end else if (up_more) begin
					fi_q <= fi_up;
					slot_q <= down_q ? oldleaf_q : leaf_x;
				end else begin
					down_q <= 1'b0;
					fi_q <= u_q;
					slot_q <= leaf_x;
				end
			end
			drks_pkg::ST_Q_ACC: begin
				acc_q <= side_q ? (acc_q - cnt_rdata) : (acc_q + cnt_rdata);
				if (dn_more) begin
					fi_q <= fi_dn;
				end else begin
					side_q <= 1'b1;
					fi_q <= lm1;
				end
			end
			drks_pkg::ST_Q_EVAL: begin
				acc_q <= '0;
				side_q <= 1'b0;
				fi_q <= r_q;
				first_q <= 1'b0;
				if (first_q) begin
					slot_q <= SW'(2);
				end else begin
					slot_q <= {node_new[SW-2:0], 1'b0};
					span_q <= span_new;
					lo_q <= lo_new;
					if (!le) k_q <= k_q - FW'(acc_q);
					pend_q.kth_value <= FW'(lo_new);
					pend_q.invalid <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == drks_pkg::ST_UPD_POS) oldleaf_q <= leaf_old;
	end

	always_ff @(posedge clk) begin
		if (state_q == drks_pkg::ST_DONE && (!out_valid || out_ready)) out_data <= pend_q;
	end

	`DRKS_ASSERT_IMPL(a_no_write_in_query, (state_q == drks_pkg::ST_Q_RD) || (state_q == drks_pkg::ST_Q_ACC) || (state_q == drks_pkg::ST_Q_EVAL), !cnt_we)
	`DRKS_ASSERT_IMPL(a_rmw_same_entry, cnt_we && (state_q == drks_pkg::ST_UPD_WR), cnt_waddr == $past(cnt_raddr))
	`DRKS_ASSERT_NEXT(a_cfg_clears, cfg_wr_en, state_q == drks_pkg::ST_CLEAR)
	`DRKS_ASSERT_IMPL(a_invalid_zero, out_valid && out_data.invalid, out_data.kth_value == '0)
endmodule

@@ bench/tb_dynamic_range_kth_smallest.sv @@
// Self-checking testbench for the dynamic range k-th smallest block.
module tb_dynamic_range_kth_smallest;
	typedef struct {
		drks_pkg::drks_in_t item;
		bit typed;
		drks_pkg::drks_out_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	drks_pkg::drks_in_t in_data;
	logic out_valid;
	logic out_ready;
	drks_pkg::drks_out_t out_data;
	logic cfg_wr_en;
	logic [drks_pkg::FIELD_W-1:0] cfg_wr_data;

	logic [drks_pkg::FIELD_W-1:0] held_value [1:drks_pkg::DEF_MAX_POSITIONS];
	int positions_in_use;
	drks_pkg::drks_out_t answers_due[$];
	int errors;
	bit fast_mode;

	dynamic_range_kth_smallest i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb_dynamic_range_kth_smallest: done, errors");
		$finish;
	end

	function automatic void empty_array(int size);
		for (int p = 1; p <= drks_pkg::DEF_MAX_POSITIONS; p++) held_value[p] = '0;
		positions_in_use = size < 1 ? 1 :
			(size > drks_pkg::DEF_MAX_POSITIONS ? drks_pkg::DEF_MAX_POSITIONS : size);
	endfunction

	function automatic int filled_in(int l, int r);
		int c;
		c = 0;
		for (int p = l; p <= r; p++) if (held_value[p] != 0) c++;
		return c;
	endfunction

	function automatic drks_pkg::drks_out_t kth_of(drks_pkg::drks_in_t q);
		drks_pkg::drks_out_t res;
		int hist [1:drks_pkg::DEF_MAX_POSITIONS];
		int l, r, k, seen;
		l = q.range_left;
		r = q.range_right;
		k = q.rank;
		res.kth_value = '0;
		res.invalid = 1'b1;
		if (l < 1 || r > positions_in_use || l > r || k < 1) return res;
		if (k > filled_in(l, r)) return res;
		for (int v = 1; v <= drks_pkg::DEF_MAX_POSITIONS; v++) hist[v] = 0;
		for (int p = l; p <= r; p++) if (held_value[p] != 0) hist[held_value[p]]++;
		seen = 0;
		for (int v = 1; v <= drks_pkg::DEF_MAX_POSITIONS; v++) begin
			seen += hist[v];
			if (seen >= k && res.invalid) begin
				res.kth_value = v[drks_pkg::FIELD_W-1:0];
				res.invalid = 1'b0;
			end
		end
		return res;
	endfunction

	function automatic void apply_set(drks_pkg::drks_in_t s);
		if (s.update_position >= 1 && s.update_position <= positions_in_use &&
				s.new_value >= 1 && s.new_value <= positions_in_use)
			held_value[s.update_position] = s.new_value;
	endfunction

	function automatic drks_pkg::drks_in_t make_set(int p, int v);
		drks_pkg::drks_in_t it;
		it = drks_pkg::drks_in_t'($urandom);
		it.operation = drks_pkg::OP_SET;
		it.update_position = p[drks_pkg::FIELD_W-1:0];
		it.new_value = v[drks_pkg::FIELD_W-1:0];
		return it;
	endfunction

	function automatic drks_pkg::drks_in_t make_query(int l, int r, int k);
		drks_pkg::drks_in_t it;
		it = drks_pkg::drks_in_t'($urandom);
		it.operation = drks_pkg::OP_QUERY;
		it.range_left = l[drks_pkg::FIELD_W-1:0];
		it.range_right = r[drks_pkg::FIELD_W-1:0];
		it.rank = k[drks_pkg::FIELD_W-1:0];
		return it;
	endfunction

	function automatic drks_pkg::drks_in_t random_item();
		drks_pkg::drks_in_t it;
		int kind, n, l, r;
		n = positions_in_use;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			it = make_set($urandom_range(1, n), $urandom_range(1, n));
		end else if (kind < 85) begin
			l = $urandom_range(1, n);
			r = $urandom_range(l, n);
			it = make_query(l, r, $urandom_range(1, filled_in(l, r) + 1));
		end else begin
			it = drks_pkg::drks_in_t'({$urandom, $urandom});
		end
		return it;
	endfunction

	task automatic send(drks_pkg::drks_in_t it, bit typed, drks_pkg::drks_out_t want);
		int gap;
		gap = fast_mode ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.operation == drks_pkg::OP_QUERY) answers_due.push_back(typed ? want : kth_of(it));
		else apply_set(it);
	endtask

	task automatic settle_and_configure(logic [drks_pkg::FIELD_W-1:0] size);
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= size;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		empty_array(size);
	endtask

	initial begin
		forever begin
			int gap;
			gap = fast_mode ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && arst_n)) @(posedge clk);
			if (answers_due.size() == 0) begin
				$error("unexpected transfer kth_value=%0d invalid=%0d",
					out_data.kth_value, out_data.invalid);
				errors++;
			end else begin
				drks_pkg::drks_out_t exp_res;
				exp_res = answers_due.pop_front();
				if (out_data.kth_value !== exp_res.kth_value) begin
					$error("kth_value expected %0d actual %0d", exp_res.kth_value,
						out_data.kth_value);
					errors++;
				end
				if (out_data.invalid !== exp_res.invalid) begin
					$error("invalid expected %0d actual %0d", exp_res.invalid,
						out_data.invalid);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		drks_pkg::drks_out_t bad;
		drks_pkg::drks_out_t none;
		logic [drks_pkg::FIELD_W-1:0] sizes[$];
		int wait_cycles;
		bad.kth_value = '0;
		bad.invalid = 1'b1;
		none = '0;
		errors = 0;
		fast_mode = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		empty_array(drks_pkg::RESET_SIZE);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back('{make_query(1, 64, 1), 1'b1, bad});
		rows.push_back('{make_query(0, 64, 1), 1'b1, bad});
		rows.push_back('{make_query(5, 4, 1), 1'b1, bad});
		rows.push_back('{make_query(1, 65, 1), 1'b1, bad});
		rows.push_back('{make_set(1, 64), 1'b0, none});
		rows.push_back('{make_set(64, 1), 1'b0, none});
		rows.push_back('{make_set(0, 3), 1'b0, none});
		rows.push_back('{make_set(3, 0), 1'b0, none});
		rows.push_back('{make_set(65, 3), 1'b0, none});
		rows.push_back('{make_set(3, 127), 1'b0, none});
		rows.push_back('{make_set(127, 9), 1'b0, none});
		rows.push_back('{make_query(1, 64, 0), 1'b1, bad});
		rows.push_back('{make_query(1, 64, 3), 1'b1, bad});
		rows.push_back('{make_query(1, 64, 1), 1'b0, none});
		rows.push_back('{make_query(1, 64, 2), 1'b0, none});
		rows.push_back('{make_set(1, 5), 1'b0, none});
		rows.push_back('{make_query(1, 64, 2), 1'b0, none});
		rows.push_back('{make_query(2, 63, 1), 1'b1, bad});
		rows.push_back('{make_query(64, 64, 1), 1'b0, none});
		rows.push_back('{make_query(1, 1, 127), 1'b1, bad});
		rows.push_back('{make_query(127, 127, 1), 1'b1, bad});
		foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);

		sizes = '{64, 1, 2, 0, 127, 7, 100, 64};
		foreach (sizes[s]) begin
			if (s > 0) settle_and_configure(sizes[s]);
			for (int i = 0; i < 170; i++) begin
				if (i % 40 == 0) fast_mode = ($urandom_range(0, 3) == 0);
				send(random_item(), 1'b0, none);
			end
			fast_mode = 1'b0;
		end
		in_valid <= 1'b0;

		while (answers_due.size() != 0) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (errors == 0 && answers_due.size() == 0) begin
			$display("tb_dynamic_range_kth_smallest: done, clean");
		end else begin
			$display("tb_dynamic_range_kth_smallest: done, errors");
		end
		$finish;
	end
endmodule

@@ dynamic_range_kth_smallest.f @@
+incdir+src
src/drks_pkg.sv
src/dynamic_range_kth_smallest.sv
bench/tb_dynamic_range_kth_smallest.sv
